### sv/hsvled_pkg.sv
`timescale 1ns / 1ps
package hsvled_pkg;

    localparam int HUE_BITS    = 16;
    localparam int H6_W        = HUE_BITS + 3;
    localparam int STEP_W      = 6;
    localparam int ENV_STEPS   = 64;
    localparam int DUTY_W      = 8;
    localparam int REG_W       = 9;
    localparam int CH_W        = 17;
    localparam int SQ_W        = 33;
    localparam int TERM_W      = HUE_BITS + 9;
    localparam int Q_DEPTH     = 2;
    localparam int PTR_W       = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W       = $clog2(Q_DEPTH + 1);
    localparam int BACK_STAGES = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [REG_W-1:0]     ONE_Q8    = REG_W'(256);
    localparam logic [REG_W-1:0]     SAT_RESET = REG_W'(230);
    localparam logic [REG_W-1:0]     VAL_RESET = REG_W'(230);
    localparam logic [CFG_IDX_W-1:0] CFG_SATURATION = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = CFG_IDX_W'(1);

    localparam logic [7:0] ENV_TABLE [0:ENV_STEPS-1] = '{
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,
        8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd9,   8'd10,  8'd12,
        8'd14,  8'd17,  8'd19,  8'd22,  8'd26,  8'd29,  8'd33,  8'd37,
        8'd42,  8'd47,  8'd52,  8'd58,  8'd64,  8'd71,  8'd77,  8'd85,
        8'd92,  8'd100, 8'd108, 8'd117, 8'd125, 8'd134, 8'd143, 8'd152,
        8'd162, 8'd171, 8'd180, 8'd189, 8'd198, 8'd206, 8'd214, 8'd222,
        8'd229, 8'd235, 8'd241, 8'd246, 8'd250, 8'd253, 8'd254, 8'd255
    };

    // hue sectors, named after the two primaries/secondaries they span
    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } t_sector;

    typedef struct packed {
        t_sector               sector;
        logic [HUE_BITS-1:0]   frac;
        logic [DUTY_W-1:0]     env;
    } t_work;

endpackage

### sv/hsvled_in_if.sv
`timescale 1ns / 1ps
interface hsvled_in_if
    import hsvled_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [HUE_BITS-1:0] hue;
    logic [STEP_W-1:0]   envelope_step;

    modport source (output valid, output hue, output envelope_step, input ready);
    modport sink   (input valid, input hue, input envelope_step, output ready);
endinterface

### sv/hsvled_out_if.sv
`timescale 1ns / 1ps
interface hsvled_out_if
    import hsvled_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] red_duty;
    logic [DUTY_W-1:0] green_duty;
    logic [DUTY_W-1:0] blue_duty;

    modport source (output valid, output red_duty, output green_duty, output blue_duty,
                    input ready);
    modport sink   (input valid, input red_duty, input green_duty, input blue_duty,
                    output ready);
endinterface

### sv/hsvled_front.sv
`timescale 1ns / 1ps
module hsvled_front
    import hsvled_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    hsvled_in_if.sink   i_in,
    input  logic        i_full,
    output logic        o_push,
    output t_work       o_work
);

    logic               r_valid;
    t_work              r_work;
    t_work              n_work;
    logic [H6_W-1:0]    n_h6;

    // hue * 6 as two shifted adds
    always_comb begin
        n_h6 = (H6_W'(i_in.hue) << 2) + (H6_W'(i_in.hue) << 1);
        n_work.sector = t_sector'(n_h6[H6_W-1:HUE_BITS]);
        n_work.frac   = n_h6[HUE_BITS-1:0];
        n_work.env    = ENV_TABLE[i_in.envelope_step];
    end

    assign i_in.ready = !r_valid || !i_full;
    assign o_push     = r_valid && !i_full;
    assign o_work     = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_work <= n_work;
        end
    end

endmodule

### sv/hsvled_queue.sv
`timescale 1ns / 1ps
module hsvled_queue
    import hsvled_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_work  i_work,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_work  o_work
);

    t_work              r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               n_take;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_work  = r_mem[r_rd_ptr];
    assign n_take  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (n_take) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !n_take) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && n_take) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

endmodule

### sv/hsvled_back.sv
`timescale 1ns / 1ps
module hsvled_back
    import hsvled_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_work             i_work,
    output logic              o_pop,
    input  logic [REG_W-1:0]  i_saturation,
    input  logic [REG_W-1:0]  i_brightness,
    hsvled_out_if.source      o_out
);

    localparam logic [TERM_W-1:0]   TERM_ONE = TERM_W'(1) << (HUE_BITS + 8);
    localparam logic [HUE_BITS:0]   ONE_H    = (HUE_BITS + 1)'(1) << HUE_BITS;

    logic                  n_en;

    // stage 1: sector terms before the value multiply
    logic                  r_v1;
    t_sector               r_sec1;
    logic [DUTY_W-1:0]     r_env1;
    logic [REG_W-1:0]      r_val1;
    logic [TERM_W-1:0]     r_aq1;
    logic [TERM_W-1:0]     r_at1;
    logic [CH_W-1:0]       r_cv1;
    logic [CH_W-1:0]       r_cp1;
    logic [REG_W-1:0]      n_s;
    logic [REG_W-1:0]      n_v;
    logic [TERM_W-1:0]     n_fs;
    logic [HUE_BITS+REG_W:0] n_fts;
    logic [2*REG_W-1:0]    n_cp;

    // stage 2: channel values routed by sector
    logic                  r_v2;
    logic [DUTY_W-1:0]     r_env2;
    logic [CH_W-1:0]       r_red2;
    logic [CH_W-1:0]       r_grn2;
    logic [CH_W-1:0]       r_blu2;
    logic [REG_W+TERM_W-1:0] n_q_prod;
    logic [REG_W+TERM_W-1:0] n_t_prod;
    logic [CH_W-1:0]       n_cq;
    logic [CH_W-1:0]       n_ct;
    logic [CH_W-1:0]       n_red;
    logic [CH_W-1:0]       n_grn;
    logic [CH_W-1:0]       n_blu;

    // stage 3: squares
    logic                  r_v3;
    logic [DUTY_W-1:0]     r_env3;
    logic [SQ_W-1:0]       r_sq_red3;
    logic [SQ_W-1:0]       r_sq_grn3;
    logic [SQ_W-1:0]       r_sq_blu3;
    logic [2*CH_W-1:0]     n_sq_red;
    logic [2*CH_W-1:0]     n_sq_grn;
    logic [2*CH_W-1:0]     n_sq_blu;

    // stage 4: output register
    logic                  r_v4;
    logic [DUTY_W-1:0]     r_duty_red;
    logic [DUTY_W-1:0]     r_duty_grn;
    logic [DUTY_W-1:0]     r_duty_blu;
    logic [DUTY_W+SQ_W-1:0] n_pr_red;
    logic [DUTY_W+SQ_W-1:0] n_pr_grn;
    logic [DUTY_W+SQ_W-1:0] n_pr_blu;

    assign n_en  = !r_v4 || o_out.ready;
    assign o_pop = n_en;

    always_comb begin
        n_s   = (i_saturation > ONE_Q8) ? ONE_Q8 : i_saturation;
        n_v   = (i_brightness > ONE_Q8) ? ONE_Q8 : i_brightness;
        n_fs  = TERM_W'(i_work.frac) * TERM_W'(n_s);
        n_fts = (HUE_BITS + REG_W + 1)'(ONE_H - (HUE_BITS + 1)'(i_work.frac))
                * (HUE_BITS + REG_W + 1)'(n_s);
        n_cp  = (2 * REG_W)'(n_v) * (2 * REG_W)'(ONE_Q8 - n_s);
    end

    always_comb begin
        n_q_prod = (REG_W + TERM_W)'(r_val1) * (REG_W + TERM_W)'(r_aq1);
        n_t_prod = (REG_W + TERM_W)'(r_val1) * (REG_W + TERM_W)'(r_at1);
        n_cq     = n_q_prod[HUE_BITS+CH_W-1:HUE_BITS];
        n_ct     = n_t_prod[HUE_BITS+CH_W-1:HUE_BITS];
        case (r_sec1)
            SEC_RY: begin
                n_red = r_cv1; n_grn = n_ct;  n_blu = r_cp1;
            end
            SEC_YG: begin
                n_red = n_cq;  n_grn = r_cv1; n_blu = r_cp1;
            end
            SEC_GC: begin
                n_red = r_cp1; n_grn = r_cv1; n_blu = n_ct;
            end
            SEC_CB: begin
                n_red = r_cp1; n_grn = n_cq;  n_blu = r_cv1;
            end
            SEC_BM: begin
                n_red = n_ct;  n_grn = r_cp1; n_blu = r_cv1;
            end
            default: begin
                n_red = r_cv1; n_grn = r_cp1; n_blu = n_cq;
            end
        endcase
    end

    always_comb begin
        n_sq_red = (2 * CH_W)'(r_red2) * (2 * CH_W)'(r_red2);
        n_sq_grn = (2 * CH_W)'(r_grn2) * (2 * CH_W)'(r_grn2);
        n_sq_blu = (2 * CH_W)'(r_blu2) * (2 * CH_W)'(r_blu2);
        n_pr_red = (DUTY_W + SQ_W)'(r_env3) * (DUTY_W + SQ_W)'(r_sq_red3);
        n_pr_grn = (DUTY_W + SQ_W)'(r_env3) * (DUTY_W + SQ_W)'(r_sq_grn3);
        n_pr_blu = (DUTY_W + SQ_W)'(r_env3) * (DUTY_W + SQ_W)'(r_sq_blu3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (n_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        if (n_en) begin
            r_sec1     <= i_work.sector;
            r_env1     <= i_work.env;
            r_val1     <= n_v;
            r_aq1      <= TERM_ONE - n_fs;
            r_at1      <= TERM_ONE - n_fts[TERM_W-1:0];
            r_cv1      <= {n_v, 8'b0};
            r_cp1      <= n_cp[CH_W-1:0];
            r_env2     <= r_env1;
            r_red2     <= n_red;
            r_grn2     <= n_grn;
            r_blu2     <= n_blu;
            r_env3     <= r_env2;
            r_sq_red3  <= n_sq_red[SQ_W-1:0];
            r_sq_grn3  <= n_sq_grn[SQ_W-1:0];
            r_sq_blu3  <= n_sq_blu[SQ_W-1:0];
            // duty is the top byte of env * c^2 in units of 1/2^32
            r_duty_red <= n_pr_red[32+DUTY_W-1:32];
            r_duty_grn <= n_pr_grn[32+DUTY_W-1:32];
            r_duty_blu <= n_pr_blu[32+DUTY_W-1:32];
        end
    end

    assign o_out.valid      = r_v4;
    assign o_out.red_duty   = r_duty_red;
    assign o_out.green_duty = r_duty_grn;
    assign o_out.blue_duty  = r_duty_blu;

endmodule

### sv/hsv_to_rgb_led_envelope_top.sv
`timescale 1ns / 1ps
// an accepted word reaches the output through the front register, queue and back pipeline
// throughput: one word per cycle sustained; the back pipeline advances whenever its
// output register is empty or taken, and a 2-word queue absorbs the front during a stall
// reset (synchronous, active low) empties front register, queue and pipeline and sets
// saturation and brightness_value to 230
module hsv_to_rgb_led_envelope_top
    import hsvled_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    hsvled_in_if.sink             i_in,
    hsvled_out_if.source          o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [REG_W-1:0]      i_cfg_wdata
);

    logic [REG_W-1:0]  r_saturation;
    logic [REG_W-1:0]  r_brightness;
    logic              q_full;
    logic              f_push;
    t_work             f_work;
    logic              q_valid;
    t_work             q_work;
    logic              b_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_saturation <= SAT_RESET;
            r_brightness <= VAL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SATURATION: r_saturation <= i_cfg_wdata;
                CFG_BRIGHTNESS: r_brightness <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    hsvled_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (f_push),
        .o_work  (f_work)
    );

    hsvled_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_work  (f_work),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_work  (q_work)
    );

    hsvled_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_work       (q_work),
        .o_pop        (b_pop),
        .i_saturation (r_saturation),
        .i_brightness (r_brightness),
        .o_out        (o_out)
    );

endmodule

### sv/hsvled_checker.sv
`timescale 1ns / 1ps
module hsvled_checker
    import hsvled_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [DUTY_W-1:0] i_red,
    input  logic [DUTY_W-1:0] i_green,
    input  logic [DUTY_W-1:0] i_blue
);

    localparam int CAP   = Q_DEPTH + BACK_STAGES + 1;
    localparam int OUT_W = $clog2(CAP + 2);

    logic [OUT_W-1:0] r_outstanding;
    logic             n_in_acc;
    logic             n_out_acc;

    assign n_in_acc  = i_in_valid && i_in_ready;
    assign n_out_acc = i_out_valid && i_out_ready;

    // words taken in but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else if (n_in_acc && !n_out_acc) begin
            r_outstanding <= r_outstanding + 1'b1;
        end else if (!n_in_acc && n_out_acc) begin
            r_outstanding <= r_outstanding - 1'b1;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_red)
            && $stable(i_green) && $stable(i_blue))
        else $error("stalled result changed or dropped");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_outstanding != '0)
        else $error("result without an accepted word");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding <= OUT_W'(CAP))
        else $error("more words in flight than storage holds");

    a_ready_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> r_outstanding != '0)
        else $error("input stalled while block is empty");

endmodule

bind hsv_to_rgb_led_envelope_top hsvled_checker u_hsvled_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_red       (o_out.red_duty),
    .i_green     (o_out.green_duty),
    .i_blue      (o_out.blue_duty)
);

### bench/hsv_to_rgb_led_envelope_top_tb.sv
`timescale 1ns / 1ps
module hsv_to_rgb_led_envelope_top_tb;
    import hsvled_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int TAIL_CYCLES = 20;

    // indexes past the two real registers, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

    typedef struct packed {
        logic [DUTY_W-1:0] red;
        logic [DUTY_W-1:0] green;
        logic [DUTY_W-1:0] blue;
    } t_duty_set;

    typedef enum logic {ROW_WORD, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [REG_W-1:0]      wdata;
        logic [HUE_BITS-1:0]   hue;
        logic [STEP_W-1:0]     step;
        bit                    typed;
        t_duty_set             duty;
    } t_led_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  reg_we;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [REG_W-1:0]      reg_wdata;

    hsvled_in_if  in_if ();
    hsvled_out_if out_if ();

    hsv_to_rgb_led_envelope_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (reg_we),
        .i_cfg_idx   (reg_idx),
        .i_cfg_wdata (reg_wdata)
    );

    logic [REG_W-1:0] sat_shadow = SAT_RESET;
    logic [REG_W-1:0] val_shadow = VAL_RESET;
    t_duty_set        expected_duty [$];
    int               mismatch_count = 0;
    int               cycle_count = 0;
    int               stall_left = 0;
    bit               calm = 1'b0;

    t_led_row directed_rows [36] = '{
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'h0000, 6'd0,  1'b1, {8'd0,   8'd0,   8'd0}},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'hFFFF, 6'd63, 1'b0, '0},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'h5555, 6'd40, 1'b0, '0},
        '{ROW_REG,  CFG_SATURATION, 9'd256, 16'h0000, 6'd0,  1'b0, '0},
        '{ROW_REG,  CFG_BRIGHTNESS, 9'd256, 16'h0000, 6'd0,  1'b0, '0},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'h0000, 6'd63, 1'b1, {8'd255, 8'd0,   8'd0}},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'h8000, 6'd63, 1'b1, {8'd0,   8'd255, 8'd255}},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'h1000, 6'd63, 1'b0, '0},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'h3800, 6'd63, 1'b0, '0},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'h6000, 6'd63, 1'b0, '0},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'h9000, 6'd63, 1'b0, '0},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'hB800, 6'd63, 1'b0, '0},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'hE000, 6'd63, 1'b0, '0},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'h2AAA, 6'd63, 1'b0, '0},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'h2AAB, 6'd63, 1'b0, '0},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'hFFFF, 6'd63, 1'b0, '0},
        '{ROW_REG,  CFG_SATURATION, 9'd0,   16'h0000, 6'd0,  1'b0, '0},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'h4321, 6'd63, 1'b1, {8'd255, 8'd255, 8'd255}},
        '{ROW_REG,  CFG_SPARE_2,    9'h1FF, 16'h0000, 6'd0,  1'b0, '0},
        '{ROW_REG,  CFG_SPARE_3,    9'd0,   16'h0000, 6'd0,  1'b0, '0},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'hABCD, 6'd63, 1'b1, {8'd255, 8'd255, 8'd255}},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'hABCD, 6'd0,  1'b1, {8'd0,   8'd0,   8'd0}},
        '{ROW_REG,  CFG_SATURATION, 9'd511, 16'h0000, 6'd0,  1'b0, '0},
        '{ROW_REG,  CFG_BRIGHTNESS, 9'd511, 16'h0000, 6'd0,  1'b0, '0},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'h0000, 6'd63, 1'b1, {8'd255, 8'd0,   8'd0}},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'h5555, 6'd63, 1'b0, '0},
        '{ROW_REG,  CFG_BRIGHTNESS, 9'd0,   16'h0000, 6'd0,  1'b0, '0},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'h7777, 6'd63, 1'b1, {8'd0,   8'd0,   8'd0}},
        '{ROW_REG,  CFG_SATURATION, 9'd1,   16'h0000, 6'd0,  1'b0, '0},
        '{ROW_REG,  CFG_BRIGHTNESS, 9'd257, 16'h0000, 6'd0,  1'b0, '0},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'h1234, 6'd31, 1'b0, '0},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'hFEDC, 6'd62, 1'b0, '0},
        '{ROW_REG,  CFG_SATURATION, 9'd230, 16'h0000, 6'd0,  1'b0, '0},
        '{ROW_REG,  CFG_BRIGHTNESS, 9'd230, 16'h0000, 6'd0,  1'b0, '0},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'hAAAA, 6'd63, 1'b0, '0},
        '{ROW_WORD, CFG_SATURATION, 9'd0,   16'h0001, 6'd1,  1'b0, '0}
    };

    always #4 i_clk = ~i_clk;

    function automatic logic [DUTY_W-1:0] gamma_duty(logic [7:0] env, logic [CH_W-1:0] level);
        logic [63:0] sq;
        logic [63:0] prod;
        sq   = 64'(level) * 64'(level);
        prod = 64'(env) * sq;
        return prod[39:32];
    endfunction

    function automatic t_duty_set predict_duty(logic [HUE_BITS-1:0] hue,
                                               logic [STEP_W-1:0] step);
        logic [REG_W-1:0]    s;
        logic [REG_W-1:0]    v;
        logic [H6_W-1:0]     h6;
        t_sector             sec;
        logic [HUE_BITS-1:0] f;
        logic [63:0]         full_one;
        logic [63:0]         cv;
        logic [63:0]         cp;
        logic [63:0]         cq;
        logic [63:0]         ct;
        logic [63:0]         r;
        logic [63:0]         g;
        logic [63:0]         b;
        logic [7:0]          env;
        t_duty_set           d;
        // register values past 1.0 saturate
        s = (sat_shadow > ONE_Q8) ? ONE_Q8 : sat_shadow;
        v = (val_shadow > ONE_Q8) ? ONE_Q8 : val_shadow;
        h6  = H6_W'(hue) * H6_W'(6);
        sec = t_sector'(h6[H6_W-1:HUE_BITS]);
        f   = h6[HUE_BITS-1:0];
        full_one = 64'(ONE_Q8) << HUE_BITS;
        cv = 64'(v) * 64'(ONE_Q8);
        cp = 64'(v) * (64'(ONE_Q8) - 64'(s));
        cq = (64'(v) * (full_one - 64'(f) * 64'(s))) >> HUE_BITS;
        ct = (64'(v) * (full_one - ((64'(1) << HUE_BITS) - 64'(f)) * 64'(s))) >> HUE_BITS;
        case (sec)
            SEC_RY: begin r = cv; g = ct; b = cp; end
            SEC_YG: begin r = cq; g = cv; b = cp; end
            SEC_GC: begin r = cp; g = cv; b = ct; end
            SEC_CB: begin r = cp; g = cq; b = cv; end
            SEC_BM: begin r = ct; g = cp; b = cv; end
            default: begin r = cv; g = cp; b = cq; end
        endcase
        env = ENV_TABLE[step];
        d.red   = gamma_duty(env, CH_W'(r));
        d.green = gamma_duty(env, CH_W'(g));
        d.blue  = gamma_duty(env, CH_W'(b));
        return d;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic send_word(input logic [HUE_BITS-1:0] hue, input logic [STEP_W-1:0] step,
                             input bit typed, input t_duty_set typed_duty);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid         <= 1'b1;
        in_if.hue           <= hue;
        in_if.envelope_step <= step;
        do @(posedge i_clk); while (!in_if.ready);
        expected_duty.push_back(typed ? typed_duty : predict_duty(hue, step));
    endtask

    task automatic drain_pipeline();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_duty.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] wdata);
        drain_pipeline();
        @(negedge i_clk);
        reg_we    <= 1'b1;
        reg_idx   <= idx;
        reg_wdata <= wdata;
        @(negedge i_clk);
        reg_we <= 1'b0;
        case (idx)
            CFG_SATURATION: sat_shadow = wdata;
            CFG_BRIGHTNESS: val_shadow = wdata;
            default: ;
        endcase
    endtask

    task automatic send_random_words(input int count);
        logic [HUE_BITS-1:0] hue;
        logic [STEP_W-1:0]   step;
        int                  k;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                // land right around a sector boundary
                k   = $urandom_range(0, 5);
                hue = HUE_BITS'((k * 65536 + 5) / 6 + $urandom_range(0, 2) - 1);
            end else begin
                hue = HUE_BITS'($urandom_range(0, 65535));
            end
            // mostly the bright end of the envelope, where duties are not all zero
            if ($urandom_range(0, 3) != 0)
                step = STEP_W'($urandom_range(32, 63));
            else
                step = STEP_W'($urandom_range(0, 63));
            send_word(hue, step, 1'b0, '0);
        end
    endtask

    // output side stalls in bursts
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left   <= $urandom_range(1, 10) - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_duty_set want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_duty.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = expected_duty.pop_front();
                if (out_if.red_duty !== want.red)
                    report_mismatch($sformatf("red_duty %0d, expected %0d",
                                              out_if.red_duty, want.red));
                if (out_if.green_duty !== want.green)
                    report_mismatch($sformatf("green_duty %0d, expected %0d",
                                              out_if.green_duty, want.green));
                if (out_if.blue_duty !== want.blue)
                    report_mismatch($sformatf("blue_duty %0d, expected %0d",
                                              out_if.blue_duty, want.blue));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** hsv_to_rgb_led_envelope_top: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [REG_W-1:0] s;
        logic [REG_W-1:0] v;
        int               n;
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        reg_we              = 1'b0;
        reg_idx             = '0;
        reg_wdata           = '0;
        in_if.valid         = 1'b0;
        in_if.hue           = '0;
        in_if.envelope_step = '0;
        out_if.ready        = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG)
                write_reg(directed_rows[i].idx, directed_rows[i].wdata);
            else
                send_word(directed_rows[i].hue, directed_rows[i].step,
                          directed_rows[i].typed, directed_rows[i].duty);
        end

        for (int p = 0; p < 7; p++) begin
            case (p)
                0: begin s = 9'd256; v = 9'd256; end
                1: begin s = 9'd0;   v = 9'd511; end
                2: begin s = 9'd511; v = 9'd0;   end
                3: begin s = 9'd257; v = 9'd200; end
                default: begin
                    s = REG_W'($urandom_range(0, 511));
                    v = REG_W'($urandom_range(0, 511));
                end
            endcase
            write_reg(CFG_SATURATION, s);
            write_reg(CFG_BRIGHTNESS, v);
            if (p == 4)
                write_reg(CFG_SPARE_2, REG_W'($urandom_range(0, 511)));
            if (p == 5)
                write_reg(CFG_SPARE_3, REG_W'($urandom_range(0, 511)));
            // last stretch runs at full rate on both sides
            calm = (p == 6);
            n = (p == 2) ? 40 : 110;
            send_random_words(n);
        end

        drain_pipeline();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_duty.size() == 0) begin
            $display("** hsv_to_rgb_led_envelope_top: PASSED **");
        end else begin
            $display("** hsv_to_rgb_led_envelope_top: FAILED **");
        end
        $finish;
    end

endmodule
